FILE: hdl/tvsd_pkg.sv
// ============================================================================
// tvsd_pkg: shared types and constants for the tagged value stream decoder
// Codes for requested types, result kinds and tag bytes, the phase encoding,
// the result record and the sign-extension helpers.
// ============================================================================
package tvsd_pkg;

    localparam int STRING_LEN_BITS = 32;
    localparam int VALUE_W         = 64;

    // Sign bit and mask of the string length field, 64-bit safe.
    localparam logic [VALUE_W-1:0] LEN_SIGN = 64'd1 << (STRING_LEN_BITS - 1);
    localparam logic [VALUE_W-1:0] LEN_MASK = (LEN_SIGN << 1) - 64'd1;

    // Requested type, sampled with the tag byte
    localparam logic [2:0] FUNC_BOOL   = 3'd0;
    localparam logic [2:0] FUNC_CHAR   = 3'd1;
    localparam logic [2:0] FUNC_SHORT  = 3'd2;
    localparam logic [2:0] FUNC_INT    = 3'd3;
    localparam logic [2:0] FUNC_LONG   = 3'd4;
    localparam logic [2:0] FUNC_STRING = 3'd5;

    // Result kinds
    localparam logic [2:0] KIND_BOOL     = 3'd0;
    localparam logic [2:0] KIND_CHAR     = 3'd1;
    localparam logic [2:0] KIND_SHORT    = 3'd2;
    localparam logic [2:0] KIND_INT      = 3'd3;
    localparam logic [2:0] KIND_LONG     = 3'd4;
    localparam logic [2:0] KIND_STR_LEN  = 3'd5;
    localparam logic [2:0] KIND_STR_BYTE = 3'd6;

    // Tag bytes (ASCII)
    localparam logic [7:0] TAG_TRUE   = 8'h74;  // t
    localparam logic [7:0] TAG_FALSE  = 8'h66;  // f
    localparam logic [7:0] TAG_CHAR   = 8'h63;  // c
    localparam logic [7:0] TAG_SHORT  = 8'h73;  // s
    localparam logic [7:0] TAG_INT    = 8'h69;  // i
    localparam logic [7:0] TAG_LONG   = 8'h6c;  // l
    localparam logic [7:0] TAG_STRING = 8'h53;  // S

    typedef enum logic [4:0] {
        PH_TAG     = 5'b00001,
        PH_CHAR    = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_STRING  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [2:0]                kind;
        logic                      error;
        logic                      last;
    } t_result;

    function automatic logic [VALUE_W-1:0] f_sext8(input logic [7:0] b);
        return {{(VALUE_W-8){b[7]}}, b};
    endfunction

    function automatic logic [VALUE_W-1:0] f_sext_len(input logic [VALUE_W-1:0] a);
        logic [VALUE_W-1:0] v;
        v = a & LEN_MASK;
        return (v ^ LEN_SIGN) - LEN_SIGN;
    endfunction

endpackage

FILE: hdl/tvsd_if.sv
// ============================================================================
// tvsd_if: stream channels of the tagged value stream decoder
// Valid/ready channels for input bytes and for decoded results.
// ============================================================================
interface tvsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [2:0] func;

    modport source (output valid, output data_byte, output func, input ready);
    modport sink   (input valid, input data_byte, input func, output ready);
endinterface

interface tvsd_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [2:0]         kind;
    logic               error;
    logic               last;

    modport source (output valid, output value, output kind, output error, output last,
                    input ready);
    modport sink   (input valid, input value, input kind, input error, input last,
                    output ready);
endinterface

FILE: hdl/tvsd_core.sv
// ============================================================================
// tvsd_core: decode state and per-byte next-state logic
// Holds the phase, accumulator, counters and sticky error; for each accepted
// byte it updates them and presents at most one result.
// ============================================================================
module tvsd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic [2:0]        i_func,
    output logic              o_res_valid,
    output tvsd_pkg::t_result o_res
);
    import tvsd_pkg::*;

    t_phase                     r_phase, n_phase;
    logic [2:0]                 r_pending_kind, n_pending_kind;
    logic [3:0]                 r_payload_left, n_payload_left;
    logic [VALUE_W-1:0]         r_acc, n_acc;
    logic [STRING_LEN_BITS-1:0] r_str_left, n_str_left;
    logic                       r_error, n_error;

    logic [VALUE_W-1:0] w_hdr_acc;
    logic [VALUE_W-1:0] w_fin_acc;
    logic [VALUE_W-1:0] w_short;
    logic [VALUE_W-1:0] w_int;
    logic [VALUE_W-1:0] w_len;
    logic               w_finish;

    assign w_hdr_acc = {{(VALUE_W-4){i_data_byte[3]}}, i_data_byte[3:0]};
    // Value the integer read completes with, header-only or after payload
    assign w_fin_acc = (r_phase == PH_HEADER) ? w_hdr_acc
                                              : {r_acc[VALUE_W-9:0], i_data_byte};
    assign w_short   = {{(VALUE_W-16){w_fin_acc[15]}}, w_fin_acc[15:0]};
    assign w_int     = {{(VALUE_W-32){w_fin_acc[31]}}, w_fin_acc[31:0]};
    assign w_len     = f_sext_len(w_fin_acc);

    always_comb begin
        n_phase        = r_phase;
        n_pending_kind = r_pending_kind;
        n_payload_left = r_payload_left;
        n_acc          = r_acc;
        n_str_left     = r_str_left;
        n_error        = r_error;
        w_finish       = 1'b0;
        o_res_valid    = 1'b0;
        o_res.value    = '0;
        o_res.kind     = KIND_BOOL;
        o_res.last     = 1'b0;

        case (r_phase)
            PH_TAG: begin
                n_pending_kind = i_func;
                case (i_func)
                    FUNC_BOOL: begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_BOOL;
                        o_res.last  = 1'b1;
                        o_res.value = (i_data_byte == TAG_TRUE) ? 64'sd1 : 64'sd0;
                        if (i_data_byte != TAG_TRUE && i_data_byte != TAG_FALSE) begin
                            n_error = 1'b1;
                        end
                    end
                    FUNC_CHAR: begin
                        if (i_data_byte != TAG_CHAR) n_error = 1'b1;
                        n_phase = PH_CHAR;
                    end
                    FUNC_SHORT: begin
                        if (i_data_byte != TAG_SHORT) n_error = 1'b1;
                        n_phase = PH_HEADER;
                    end
                    FUNC_INT: begin
                        if (i_data_byte != TAG_INT) n_error = 1'b1;
                        n_phase = PH_HEADER;
                    end
                    FUNC_LONG: begin
                        if (i_data_byte != TAG_LONG) n_error = 1'b1;
                        n_phase = PH_HEADER;
                    end
                    FUNC_STRING: begin
                        if (i_data_byte != TAG_STRING) n_error = 1'b1;
                        n_phase = PH_HEADER;
                    end
                    default: begin
                        // unknown type: byte dropped, keep waiting for a tag
                        n_error = 1'b1;
                    end
                endcase
            end
            PH_CHAR: begin
                n_phase     = PH_TAG;
                o_res_valid = 1'b1;
                o_res.kind  = KIND_CHAR;
                o_res.last  = 1'b1;
                o_res.value = f_sext8(i_data_byte);
            end
            PH_HEADER: begin
                n_acc          = w_hdr_acc;
                n_payload_left = i_data_byte[7:4];
                if (i_data_byte[7:4] == 4'd0) begin
                    w_finish = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_acc          = w_fin_acc;
                n_payload_left = r_payload_left - 4'd1;
                if (r_payload_left == 4'd1) w_finish = 1'b1;
            end
            PH_STRING: begin
                n_str_left  = r_str_left - STRING_LEN_BITS'(1);
                o_res_valid = 1'b1;
                o_res.kind  = KIND_STR_BYTE;
                o_res.value = f_sext8(i_data_byte);
                if (r_str_left == STRING_LEN_BITS'(1)) begin
                    o_res.last = 1'b1;
                    n_phase    = PH_TAG;
                end
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase

        if (w_finish) begin
            n_phase     = PH_TAG;
            o_res_valid = 1'b1;
            o_res.last  = 1'b1;
            case (r_pending_kind)
                FUNC_SHORT: begin
                    o_res.kind  = KIND_SHORT;
                    o_res.value = w_short;
                    if (w_short != w_fin_acc) n_error = 1'b1;
                end
                FUNC_INT: begin
                    o_res.kind  = KIND_INT;
                    o_res.value = w_int;
                    if (w_int != w_fin_acc) n_error = 1'b1;
                end
                FUNC_LONG: begin
                    o_res.kind  = KIND_LONG;
                    o_res.value = w_fin_acc;
                end
                default: begin
                    // string length; zero or negative means an empty string
                    o_res.kind  = KIND_STR_LEN;
                    o_res.value = w_len;
                    if (w_len[VALUE_W-1] || w_len == '0) begin
                        n_str_left = '0;
                    end else begin
                        n_str_left = w_len[STRING_LEN_BITS-1:0];
                        n_phase    = PH_STRING;
                        o_res.last = 1'b0;
                    end
                end
            endcase
        end

        o_res.error = n_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_TAG;
            r_pending_kind <= FUNC_BOOL;
            r_payload_left <= '0;
            r_str_left     <= '0;
            r_error        <= 1'b0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_pending_kind <= n_pending_kind;
            r_payload_left <= n_payload_left;
            r_str_left     <= n_str_left;
            r_error        <= n_error;
        end
    end

    // accumulator is always loaded by a header byte before it is used
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_acc <= n_acc;
        end
    end

endmodule

FILE: hdl/tagged_value_stream_decoder_top.sv
// A result is registered and appears on o_out in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the result register takes a new result
// while the current one is being taken, so only a result held with o_out.ready low stalls input.
// Reset (synchronous, i_rst_n low): waits for a tag, sticky error cleared,
// output register empty.
// ============================================================================
// tagged_value_stream_decoder_top: byte-stream tagged value decoder
// Decode core followed by a result register on the output channel.
// ============================================================================
module tagged_value_stream_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tvsd_in_if.sink    i_in,
    tvsd_out_if.source o_out
);
    import tvsd_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    logic    r_out_valid;
    t_result r_out;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    tvsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_in.data_byte),
        .i_func      (i_in.func),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out.value;
    assign o_out.kind  = r_out.kind;
    assign o_out.error = r_out.error;
    assign o_out.last  = r_out.last;

endmodule

FILE: hdl/tvsd_checker.sv
// ============================================================================
// tvsd_checker: port-level checks for the tagged value stream decoder
// Watches the channels of the top level and flags protocol or decode slips.
// ============================================================================
module tvsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_value,
    input logic [2:0]  i_out_kind,
    input logic        i_out_error
);
    import tvsd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("result changed while stalled");

    // the input is only back-pressured by a stalled result
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // once reported, the error flag stays set until reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |=> !i_out_valid || i_out_error)
        else $error("sticky error cleared");

    a_bool_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_BOOL |-> i_out_value == 64'd0 || i_out_value == 64'd1)
        else $error("bool result not 0 or 1");

    a_short_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_SHORT
        |-> i_out_value[63:15] == '0 || i_out_value[63:15] == '1)
        else $error("short result not sign-extended");

endmodule

bind tagged_value_stream_decoder_top tvsd_checker u_tvsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value),
    .i_out_kind  (o_out.kind),
    .i_out_error (o_out.error)
);
